/* hw/rtl/sefu_pkg.sv */
// ----------------------------------------------------------------------------
// sefu_pkg
// Shared types, register indexes and helpers for the stereo echo FIR unit.
// ----------------------------------------------------------------------------
package sefu_pkg;

    localparam int TAPS    = 8;
    localparam int TAP_W   = $clog2(TAPS);
    localparam int HIST_AW = TAP_W + 1;
    localparam int HIST_DEPTH = 1 << HIST_AW;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIR_COEFS     = 3'd0,
        REG_FEEDBACK      = 3'd1,
        REG_VOLUMES       = 3'd2,
        REG_ECHO_PAGE     = 3'd3,
        REG_ECHO_DELAY    = 3'd4,
        REG_WRITE_DISABLE = 3'd5,
        REG_MUTE          = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic signed [15:0] dry_left;
        logic signed [15:0] dry_right;
        logic signed [15:0] send_left;
        logic signed [15:0] send_right;
        logic signed [15:0] ram_left;
        logic signed [15:0] ram_right;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] out_left;
        logic signed [15:0] out_right;
        logic        [15:0] write_address;
        logic signed [15:0] wr_left_word;
        logic signed [15:0] wr_right_word;
        logic               wr_left_en;
        logic               wr_right_en;
        logic        [15:0] next_address;
    } out_item_t;

    // request from the sequencer to the FIR engine
    typedef struct packed {
        logic               start;
        logic signed [15:0] ram_left;
        logic signed [15:0] ram_right;
    } fir_req_t;

    // FIR engine status back to the sequencer
    typedef struct packed {
        logic               done;
        logic signed [15:0] fir_left;
        logic signed [15:0] fir_right;
    } fir_rsp_t;

    // Tap coefficient; only the first eight taps have a coefficient byte.
    function automatic logic signed [7:0] fir_coef(input logic [63:0] coefs,
                                                   input logic [TAP_W-1:0] k);
        logic signed [7:0] c;
        c = '0;
        for (int i = 0; i < 8; i++) begin
            if (int'(k) == i) begin
                c = coefs[8*i +: 8];
            end
        end
        return c;
    endfunction

endpackage

/* hw/rtl/sefu_fir.sv */
// ----------------------------------------------------------------------------
// sefu_fir
// Echo history memory and sequential two-channel FIR over one multiplier.
// ----------------------------------------------------------------------------
module sefu_fir (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [63:0]       fir_coefs,
    input  sefu_pkg::fir_req_t req,
    output sefu_pkg::fir_rsp_t rsp
);

    typedef enum logic [2:0] {
        C_IDLE,
        C_WR0,
        C_WR1,
        C_RD,
        C_DRAIN
    } core_state_t;

    core_state_t state_reg;

    logic [sefu_pkg::TAP_W-1:0] ptr_reg;
    logic [sefu_pkg::TAP_W-1:0] k_reg;
    logic                       ch_reg;
    logic [14:0]                half_l_reg;
    logic [14:0]                half_r_reg;

    // history memory, entry {channel, slot}
    logic [14:0]                    mem [sefu_pkg::HIST_DEPTH];
    logic [sefu_pkg::HIST_DEPTH-1:0] vld_bits_reg;
    logic                           mem_we;
    logic [sefu_pkg::HIST_AW-1:0]   mem_waddr;
    logic [14:0]                    mem_wdata;
    logic [sefu_pkg::HIST_AW-1:0]   rd_addr;
    logic [14:0]                    rd_data_reg;
    logic                           rd_vld_reg;

    // pipeline stages behind the read
    logic                s1_vld_reg;
    logic                s1_ch_reg;
    logic                s1_last_reg;
    logic signed [7:0]   s1_coef_reg;
    logic                s2_vld_reg;
    logic                s2_ch_reg;
    logic                s2_last_reg;
    logic signed [22:0]  s2_prod_reg;
    logic signed [15:0]  acc_reg [2];
    logic                done_reg;

    logic [sefu_pkg::TAP_W-1:0] ptr_next;
    logic [sefu_pkg::TAP_W:0]   idx_sum;
    logic [sefu_pkg::TAP_W-1:0] idx;
    logic signed [14:0]         sample;
    logic                       last_issue;

    assign ptr_next = (ptr_reg == sefu_pkg::TAP_W'(sefu_pkg::TAPS - 1)) ?
                      '0 : ptr_reg + 1'b1;

    // slot of tap k: (ptr + k + 1) mod TAPS
    always_comb begin
        idx_sum = {1'b0, ptr_reg} + {1'b0, k_reg} + 1'b1;
        if (idx_sum >= (sefu_pkg::TAP_W + 1)'(sefu_pkg::TAPS)) begin
            idx_sum = idx_sum - (sefu_pkg::TAP_W + 1)'(sefu_pkg::TAPS);
        end
        idx = idx_sum[sefu_pkg::TAP_W-1:0];
    end

    assign rd_addr    = {ch_reg, idx};
    assign last_issue = ch_reg && (k_reg == sefu_pkg::TAP_W'(sefu_pkg::TAPS - 1));

    always_comb begin
        mem_we    = (state_reg == C_WR0) || (state_reg == C_WR1);
        mem_waddr = {(state_reg == C_WR1), ptr_reg};
        mem_wdata = (state_reg == C_WR1) ? half_r_reg : half_l_reg;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // entries never written read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_bits_reg <= '0;
            rd_vld_reg   <= 1'b0;
        end else begin
            if (mem_we) begin
                vld_bits_reg[mem_waddr] <= 1'b1;
            end
            rd_vld_reg <= vld_bits_reg[rd_addr];
        end
    end

    assign sample = rd_vld_reg ? $signed(rd_data_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= C_IDLE;
            ptr_reg     <= '0;
            k_reg       <= '0;
            ch_reg      <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            done_reg   <= 1'b0;
            s1_vld_reg <= 1'b0;

            // stage 2: product of sample and coefficient
            s2_vld_reg  <= s1_vld_reg;
            s2_ch_reg   <= s1_ch_reg;
            s2_last_reg <= s1_last_reg;
            s2_prod_reg <= sample * s1_coef_reg;

            // stage 3: accumulate with 16-bit wrap
            if (s2_vld_reg) begin
                acc_reg[s2_ch_reg] <= acc_reg[s2_ch_reg] + s2_prod_reg[21:6];
                if (s2_last_reg) begin
                    done_reg <= 1'b1;
                end
            end

            case (state_reg)
                C_IDLE: begin
                    if (req.start) begin
                        ptr_reg    <= ptr_next;
                        half_l_reg <= req.ram_left[15:1];
                        half_r_reg <= req.ram_right[15:1];
                        acc_reg[0] <= '0;
                        acc_reg[1] <= '0;
                        k_reg      <= '0;
                        ch_reg     <= 1'b0;
                        state_reg  <= C_WR0;
                    end
                end
                C_WR0: begin
                    state_reg <= C_WR1;
                end
                C_WR1: begin
                    state_reg <= C_RD;
                end
                C_RD: begin
                    s1_vld_reg  <= 1'b1;
                    s1_ch_reg   <= ch_reg;
                    s1_last_reg <= last_issue;
                    s1_coef_reg <= sefu_pkg::fir_coef(fir_coefs, k_reg);
                    if (k_reg == sefu_pkg::TAP_W'(sefu_pkg::TAPS - 1)) begin
                        k_reg  <= '0;
                        ch_reg <= 1'b1;
                    end else begin
                        k_reg <= k_reg + 1'b1;
                    end
                    if (last_issue) begin
                        state_reg <= C_DRAIN;
                    end
                end
                C_DRAIN: begin
                    if (s2_vld_reg && s2_last_reg) begin
                        state_reg <= C_IDLE;
                    end
                end
                default: begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.fir_left  = acc_reg[0];
    assign rsp.fir_right = acc_reg[1];

endmodule

/* hw/rtl/stereo_echo_fir_unit.sv */
// ----------------------------------------------------------------------------
// stereo_echo_fir_unit
// Echo section of a stereo mixer: FIR over the echo history, volumes,
// feedback write-back words and echo ring addressing.
// ----------------------------------------------------------------------------
// One beat in is one stereo sample period; one beat out follows for each.
// After acceptance the result register loads once these steps are done:
// two history writes, then 2*TAPS reads of the history memory, one per
// cycle, feeding one shared multiplier, a drain through the product and
// accumulate registers and the done handoff, a step of volume and
// feedback products and a step of final sums. The input is ready again
// as the result register loads; no new item is taken before then. The
// next item is accepted while the previous result still waits on m_ready;
// if that result is still waiting when the next final step is reached,
// hold that step until it leaves. Configuration writes land at once;
// write only while idle.
// ----------------------------------------------------------------------------
module stereo_echo_fir_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [sefu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sefu_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  sefu_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output sefu_pkg::out_item_t                 m_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIR,
        ST_MIX,
        ST_FIN
    } top_state_t;

    // configuration registers
    logic [63:0]        fir_coefs_reg;
    logic signed [7:0]  feedback_reg;
    logic [31:0]        volumes_reg;
    logic [7:0]         echo_page_reg;
    logic [3:0]         echo_delay_reg;
    logic               write_disable_reg;
    logic               mute_reg;

    // ring state
    logic [15:0]        ring_offset_reg;
    logic [15:0]        ring_length_reg;
    logic [7:0]         page_latch_reg;
    logic               disable_latch_reg;

    top_state_t         state_reg;
    sefu_pkg::in_item_t item_reg;
    logic [15:0]        addr_reg;
    logic [15:0]        next_addr_reg;
    logic               en_left_reg;
    logic               en_right_reg;

    // registered products
    logic signed [23:0] p_dry_reg  [2];
    logic signed [23:0] p_echo_reg [2];
    logic signed [23:0] p_fb_reg   [2];

    logic               m_valid_reg;
    sefu_pkg::out_item_t m_data_reg;

    sefu_pkg::fir_req_t fir_req;
    sefu_pkg::fir_rsp_t fir_rsp;

    logic               s_fire;
    logic               out_free;
    logic [15:0]        len_upd;
    logic [15:0]        off_inc;
    logic [15:0]        off_upd;
    logic signed [15:0] sum_l;
    logic signed [15:0] sum_r;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // ------------------------------------------------------------------
    // Configuration port: take the low bits of the data for narrow regs.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fir_coefs_reg     <= '0;
            feedback_reg      <= '0;
            volumes_reg       <= '0;
            echo_page_reg     <= '0;
            echo_delay_reg    <= '0;
            write_disable_reg <= 1'b1;
            mute_reg          <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                sefu_pkg::REG_FIR_COEFS:     fir_coefs_reg     <= cfg_data;
                sefu_pkg::REG_FEEDBACK:      feedback_reg      <= cfg_data[7:0];
                sefu_pkg::REG_VOLUMES:       volumes_reg       <= cfg_data[31:0];
                sefu_pkg::REG_ECHO_PAGE:     echo_page_reg     <= cfg_data[7:0];
                sefu_pkg::REG_ECHO_DELAY:    echo_delay_reg    <= cfg_data[3:0];
                sefu_pkg::REG_WRITE_DISABLE: write_disable_reg <= cfg_data[0];
                sefu_pkg::REG_MUTE:          mute_reg          <= cfg_data[0];
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Ring stepping for the period being accepted. The length reloads
    // only at the start of the ring; the offset steps by one stereo word
    // pair and wraps when it reaches or passes the length.
    // ------------------------------------------------------------------
    always_comb begin
        len_upd = (ring_offset_reg == '0) ? {1'b0, echo_delay_reg, 11'd0}
                                          : ring_length_reg;
        off_inc = ring_offset_reg + 16'd4;
        off_upd = (off_inc >= len_upd) ? '0 : off_inc;
    end

    // ------------------------------------------------------------------
    // FIR engine
    // ------------------------------------------------------------------
    assign fir_req.start     = s_fire;
    assign fir_req.ram_left  = s_data.ram_left;
    assign fir_req.ram_right = s_data.ram_right;

    sefu_fir u_fir (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fir_coefs (fir_coefs_reg),
        .req       (fir_req),
        .rsp       (fir_rsp)
    );

    // final sums: wrap each scaled term to 16 bits, then wrap the sum
    assign sum_l = p_dry_reg[0][22:7] + p_echo_reg[0][22:7];
    assign sum_r = p_dry_reg[1][22:7] + p_echo_reg[1][22:7];

    // ------------------------------------------------------------------
    // Sequencer and output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            ring_offset_reg   <= '0;
            ring_length_reg   <= '0;
            page_latch_reg    <= '0;
            disable_latch_reg <= 1'b1;
            m_valid_reg       <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        // latch the item and advance the ring for next period
                        item_reg          <= s_data;
                        addr_reg          <= {page_latch_reg, 8'd0} + ring_offset_reg;
                        next_addr_reg     <= {echo_page_reg, 8'd0} + off_upd;
                        page_latch_reg    <= echo_page_reg;
                        ring_length_reg   <= len_upd;
                        ring_offset_reg   <= off_upd;
                        en_left_reg       <= !disable_latch_reg;
                        en_right_reg      <= !write_disable_reg;
                        disable_latch_reg <= write_disable_reg;
                        state_reg         <= ST_FIR;
                    end
                end
                ST_FIR: begin
                    if (fir_rsp.done) begin
                        state_reg <= ST_MIX;
                    end
                end
                ST_MIX: begin
                    p_dry_reg[0]  <= item_reg.dry_left  * $signed(volumes_reg[7:0]);
                    p_dry_reg[1]  <= item_reg.dry_right * $signed(volumes_reg[15:8]);
                    p_echo_reg[0] <= fir_rsp.fir_left   * $signed(volumes_reg[23:16]);
                    p_echo_reg[1] <= fir_rsp.fir_right  * $signed(volumes_reg[31:24]);
                    p_fb_reg[0]   <= fir_rsp.fir_left   * feedback_reg;
                    p_fb_reg[1]   <= fir_rsp.fir_right  * feedback_reg;
                    state_reg     <= ST_FIN;
                end
                ST_FIN: begin
                    // hold until the output slot is free
                    if (out_free) begin
                        m_valid_reg                <= 1'b1;
                        m_data_reg.out_left        <= mute_reg ? '0 : sum_l;
                        m_data_reg.out_right       <= mute_reg ? '0 : sum_r;
                        m_data_reg.write_address   <= addr_reg;
                        m_data_reg.wr_left_word    <= item_reg.send_left
                                                      + p_fb_reg[0][22:7];
                        m_data_reg.wr_right_word   <= item_reg.send_right
                                                      + p_fb_reg[1][22:7];
                        m_data_reg.wr_left_en      <= en_left_reg;
                        m_data_reg.wr_right_en     <= en_right_reg;
                        m_data_reg.next_address    <= next_addr_reg;
                        state_reg                  <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef NO_ASSERTIONS
    // the FIR engine only finishes while the sequencer waits for it
    a_done_in_fir: assert property (@(posedge aclk) disable iff (!aresetn)
        fir_rsp.done |-> (state_reg == ST_FIR))
        else $error("FIR done outside of FIR wait");

    // a new result only appears after the final-sum step
    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !$past(m_valid_reg)) |-> $past(state_reg == ST_FIN))
        else $error("result loaded outside of final step");

    // an accepted item blocks further input until its result is formed
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_ready)
        else $error("input accepted while busy");

    // a result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(m_data_reg)))
        else $error("pending result overwritten");
`endif

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stereo echo FIR unit: a queue-fed driver, a
// monitor that scores every output beat against a cycle-free model of the
// echo section (history, FIR, volumes, feedback words, ring addressing and
// write strobes), and register phases run only while the unit is idle.
// ----------------------------------------------------------------------------
module tb;

    // index outside the register map; the unit must ignore it
    localparam logic [sefu_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
    // cycles from acceptance to result, plus margin
    localparam int SETTLE_CYCLES = 2 * sefu_pkg::TAPS + 14;

    logic                            aclk;
    logic                            aresetn   = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [sefu_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [sefu_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    sefu_pkg::in_item_t              s_data    = '0;
    logic                            m_valid;
    logic                            m_ready   = 1'b0;
    sefu_pkg::out_item_t             m_data;

    stereo_echo_fir_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Shadow copy of the register file, updated as each write is issued.
    logic [63:0] coef_bytes;
    logic [7:0]  fb_gain;
    logic [31:0] vol_bytes;
    logic [7:0]  echo_page_reg;
    logic [3:0]  echo_delay_reg;
    logic        wr_disable_reg;
    logic        mute_reg;

    // Model state of the echo section.
    int          echo_hist [2][sefu_pkg::TAPS];
    int          hist_ptr;
    logic [15:0] ring_offset;
    logic [15:0] ring_length;
    logic [7:0]  page_latch;
    logic        wr_block_latch;

    sefu_pkg::in_item_t  periods_to_send [$];
    sefu_pkg::out_item_t echo_results_due [$];
    int        mismatches  = 0;
    bit        steady_flow = 1'b0;   // when set, neither side idles

    logic [15:0] corner_vals [4] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};

    function automatic int wrap16(int x);
        logic signed [15:0] t;
        t = x[15:0];
        return t;
    endfunction

    // FIR over one channel: tap 0 is the oldest sample, the last tap the newest.
    function automatic int fir_sum(int ch);
        int                acc;
        int                term;
        logic signed [7:0] c;
        acc = 0;
        for (int k = 0; k < sefu_pkg::TAPS; k++) begin
            c = (k < 8) ? coef_bytes[8*k +: 8] : 8'sd0;
            term = echo_hist[ch][(hist_ptr + k + 1) % sefu_pkg::TAPS] * c;
            acc = wrap16(acc + (term >>> 6));
        end
        return acc;
    endfunction

    // One stereo sample period: returns the output beat it must produce.
    function automatic sefu_pkg::out_item_t predict_echo_period(sefu_pkg::in_item_t x);
        sefu_pkg::out_item_t r;
        int        dry [2];
        int        send [2];
        int        fir;
        int        mvol;
        int        evol;
        int        fb;
        int        mix;
        int        word;
        dry[0]  = x.dry_left;
        dry[1]  = x.dry_right;
        send[0] = x.send_left;
        send[1] = x.send_right;
        r = '0;

        hist_ptr = (hist_ptr + 1) % sefu_pkg::TAPS;
        r.write_address = {page_latch, 8'h00} + ring_offset;
        echo_hist[0][hist_ptr] = int'(x.ram_left) >>> 1;
        echo_hist[1][hist_ptr] = int'(x.ram_right) >>> 1;

        fb = $signed(fb_gain);
        for (int ch = 0; ch < 2; ch++) begin
            mvol = $signed(vol_bytes[8*ch +: 8]);
            evol = $signed(vol_bytes[16 + 8*ch +: 8]);
            fir  = fir_sum(ch);
            mix  = wrap16(wrap16((dry[ch] * mvol) >>> 7) + wrap16((fir * evol) >>> 7));
            if (mute_reg) begin
                mix = 0;
            end
            word = wrap16(send[ch] + ((fir * fb) >>> 7));
            if (ch == 0) begin
                r.out_left     = mix[15:0];
                r.wr_left_word = word[15:0];
            end else begin
                r.out_right     = mix[15:0];
                r.wr_right_word = word[15:0];
            end
        end

        // Advance the ring; length reloads only at the ring start.
        page_latch = echo_page_reg;
        if (ring_offset == 16'd0) begin
            ring_length = {1'b0, echo_delay_reg, 11'd0};
        end
        ring_offset = ring_offset + 16'd4;
        if (ring_offset >= ring_length) begin
            ring_offset = 16'd0;
        end

        // Left strobe uses last period's latch, right strobe the fresh one.
        r.wr_left_en   = !wr_block_latch;
        wr_block_latch = wr_disable_reg;
        r.wr_right_en  = !wr_block_latch;
        r.next_address = {page_latch, 8'h00} + ring_offset;
        return r;
    endfunction

    function automatic sefu_pkg::in_item_t corner_period(int i);
        sefu_pkg::in_item_t x;
        x.dry_left   = corner_vals[(i + 0) % 4];
        x.dry_right  = corner_vals[(i + 1) % 4];
        x.send_left  = corner_vals[(i + 2) % 4];
        x.send_right = corner_vals[(i + 3) % 4];
        x.ram_left   = corner_vals[(i + 1) % 4];
        x.ram_right  = corner_vals[(i + 0) % 4];
        return x;
    endfunction

    // Mostly full-range random, with the signed extremes mixed in.
    function automatic logic [15:0] rand_sample();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic write_reg(logic [sefu_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            sefu_pkg::REG_FIR_COEFS:     coef_bytes     = val;
            sefu_pkg::REG_FEEDBACK:      fb_gain        = val[7:0];
            sefu_pkg::REG_VOLUMES:       vol_bytes      = val[31:0];
            sefu_pkg::REG_ECHO_PAGE:     echo_page_reg  = val[7:0];
            sefu_pkg::REG_ECHO_DELAY:    echo_delay_reg = val[3:0];
            sefu_pkg::REG_WRITE_DISABLE: wr_disable_reg = val[0];
            sefu_pkg::REG_MUTE:          mute_reg       = val[0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Random register set; upper bits carry noise to check masking.
    task automatic shuffle_config();
        logic [63:0] noise;
        write_reg(sefu_pkg::REG_FIR_COEFS, {$urandom, $urandom});
        write_reg(sefu_pkg::REG_FEEDBACK, {$urandom, $urandom});
        write_reg(sefu_pkg::REG_VOLUMES, {$urandom, $urandom});
        write_reg(sefu_pkg::REG_ECHO_PAGE, {$urandom, $urandom});
        // keep the ring short most of the time so it wraps within the run
        noise = {$urandom, $urandom};
        case ($urandom_range(19))
            0, 1, 2:                     noise[3:0] = 4'd0;
            3, 4, 5, 6, 7, 8, 9, 10, 11: noise[3:0] = 4'd1;
            default: ;
        endcase
        write_reg(sefu_pkg::REG_ECHO_DELAY, noise);
        write_reg(sefu_pkg::REG_WRITE_DISABLE, {$urandom, $urandom});
        noise = {$urandom, $urandom};
        noise[0] = ($urandom_range(4) == 0);
        write_reg(sefu_pkg::REG_MUTE, noise);
        if ($urandom_range(3) == 0) begin
            write_reg(REG_UNMAPPED, {$urandom, $urandom});
        end
    endtask

    // Hold until every beat is sent and scored, then let the pipe settle.
    task automatic drain_block();
        @(negedge aclk);
        while (periods_to_send.size() != 0 || s_valid || echo_results_due.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Driver: present the next pending period; hold it until accepted.
    // Score each accepted beat into the model at the edge that takes it.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                echo_results_due.push_back(predict_echo_period(s_data));
            end
            if (!s_valid || s_ready) begin
                if (periods_to_send.size() != 0 &&
                    (steady_flow || $urandom_range(99) >= 14)) begin
                    s_valid <= 1'b1;
                    s_data  <= periods_to_send.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall the result channel at random, compare each beat taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady_flow || ($urandom_range(99) >= 14);
            if (m_valid && m_ready) begin
                if (echo_results_due.size() == 0) begin
                    $display("%0t: unexpected beat, expected none got %p", $time, m_data);
                    mismatches++;
                end else begin
                    sefu_pkg::out_item_t want;
                    want = echo_results_due.pop_front();
                    check_field("out_left", want.out_left, m_data.out_left);
                    check_field("out_right", want.out_right, m_data.out_right);
                    check_field("write_address", want.write_address, m_data.write_address);
                    check_field("wr_left_word", want.wr_left_word, m_data.wr_left_word);
                    check_field("wr_right_word", want.wr_right_word, m_data.wr_right_word);
                    check_field("wr_left_en", want.wr_left_en, m_data.wr_left_en);
                    check_field("wr_right_en", want.wr_right_en, m_data.wr_right_en);
                    check_field("next_address", want.next_address, m_data.next_address);
                end
            end
        end
    end

    // Stimulus: reset, directed corner phases, then random register phases.
    initial begin
        coef_bytes     = '0;
        fb_gain        = '0;
        vol_bytes      = '0;
        echo_page_reg  = '0;
        echo_delay_reg = '0;
        wr_disable_reg = 1'b1;
        mute_reg       = 1'b0;
        foreach (echo_hist[c, k]) echo_hist[c][k] = 0;
        hist_ptr       = 0;
        ring_offset    = '0;
        ring_length    = '0;
        page_latch     = '0;
        wr_block_latch = 1'b1;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset registers: zero delay, writes disabled, all taps zero.
        @(negedge aclk);
        for (int i = 0; i < 6; i++) periods_to_send.push_back(corner_period(i));
        drain_block();

        // Negative extremes, longest ring at the top page, writes enabled.
        write_reg(sefu_pkg::REG_FIR_COEFS, 64'h8080_8080_8080_8080);
        write_reg(sefu_pkg::REG_FEEDBACK, 64'h80);
        write_reg(sefu_pkg::REG_VOLUMES, 64'h8080_8080);
        write_reg(sefu_pkg::REG_ECHO_PAGE, 64'hFF);
        write_reg(sefu_pkg::REG_ECHO_DELAY, 64'hF);
        write_reg(sefu_pkg::REG_WRITE_DISABLE, 64'h0);
        write_reg(sefu_pkg::REG_MUTE, 64'h0);
        @(negedge aclk);
        for (int i = 0; i < 8; i++) periods_to_send.push_back(corner_period(i));
        drain_block();

        // Positive extremes, muted, one-unit ring, writes disabled again,
        // plus a write to an unmapped index that must change nothing.
        write_reg(sefu_pkg::REG_FIR_COEFS, 64'h7F7F_7F7F_7F7F_7F7F);
        write_reg(sefu_pkg::REG_FEEDBACK, 64'h7F);
        write_reg(sefu_pkg::REG_VOLUMES, 64'h7F7F_7F7F);
        write_reg(sefu_pkg::REG_ECHO_PAGE, 64'h00);
        write_reg(sefu_pkg::REG_ECHO_DELAY, 64'h1);
        write_reg(sefu_pkg::REG_WRITE_DISABLE, 64'h1);
        write_reg(sefu_pkg::REG_MUTE, 64'h1);
        write_reg(REG_UNMAPPED, 64'hFFFF_FFFF_FFFF_FFFF);
        @(negedge aclk);
        for (int i = 0; i < 8; i++) periods_to_send.push_back(corner_period(i + 2));
        drain_block();

        for (int p = 0; p < 12; p++) begin
            shuffle_config();
            @(negedge aclk);
            steady_flow = (p == 5);
            repeat (120) begin
                sefu_pkg::in_item_t x;
                x.dry_left   = rand_sample();
                x.dry_right  = rand_sample();
                x.send_left  = rand_sample();
                x.send_right = rand_sample();
                x.ram_left   = rand_sample();
                x.ram_right  = rand_sample();
                periods_to_send.push_back(x);
            end
            drain_block();
            steady_flow = 1'b0;
        end

        if (mismatches == 0 && echo_results_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
